FILE: design/brld_pkg.sv
`default_nettype none

package brld_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int BYTE_W      = 8;
	localparam int PLEN_W      = 4;
	localparam int LINE_W      = 18;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = LINE_W;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int DATA_W      = MAX_PATTERN * BYTE_W;
	localparam int PROD_W      = BYTE_W + PLEN_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [PLEN_W-1:0] PAT_LEN_RESET    = PLEN_W'(2);
	localparam logic [LINE_W-1:0] LINE_BYTES_RESET = LINE_W'(80);

	localparam logic [BYTE_W-1:0] TAG_LITERAL = 8'h80;
	localparam logic [BYTE_W-1:0] COUNT_MASK  = 8'h7f;
	localparam logic [BYTE_W-1:0] BYTE_ONES   = 8'hff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LEN    = 1'b0,
		REG_LINE_BYTES = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_TAG       = 3'd0,
		PH_PAT_COUNT = 3'd1,
		PH_PAT_BYTES = 3'd2,
		PH_LIT_COUNT = 3'd3,
		PH_LIT_BYTES = 3'd4,
		PH_REPEAT_N  = 3'd5
	} phase_t;

	// Byte classes that the parser branches on.
	typedef enum logic [1:0] {
		CLS_ZERO    = 2'd0,
		CLS_LITERAL = 2'd1,
		CLS_ONES    = 2'd2,
		CLS_OTHER   = 2'd3
	} byte_cls_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_REPEAT = 1'b1
	} res_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              start;
		byte_cls_t         cls;
	} byte_item_t;

	typedef struct packed {
		logic                  valid;
		cfg_reg_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		res_kind_t         kind;
		logic [DATA_W-1:0] run_data;
		logic [PLEN_W-1:0] byte_count;
		logic [BYTE_W-1:0] repeat_res;
		logic              end_of_line;
	} result_t;

	typedef struct packed {
		logic [LINE_W-1:0] left;
		logic              done;
	} line_upd_t;

	function automatic logic [PLEN_W-1:0] eff_pattern(input logic [PLEN_W-1:0] len);
		logic [PLEN_W-1:0] v;
		v = len;
		if (v == '0) begin
			v = PLEN_W'(1);
		end
		if (v > PLEN_W'(MAX_PATTERN)) begin
			v = PLEN_W'(MAX_PATTERN);
		end
		return v;
	endfunction

	function automatic logic [LINE_W-1:0] eff_line(input logic [LINE_W-1:0] len);
		return (len == '0) ? LINE_W'(1) : len;
	endfunction

	// Takes a run's decoded size off the bytes left in the line, saturating
	// at zero; a line that runs out is reloaded and flagged as done.
	function automatic line_upd_t line_consume(input logic [LINE_W-1:0] left,
		input logic [LINE_W-1:0] amount, input logic [LINE_W-1:0] reload);
		line_upd_t         u;
		logic [LINE_W-1:0] rem;
		rem = (amount >= left) ? '0 : left - amount;
		u.done = (rem == '0);
		u.left = u.done ? reload : rem;
		return u;
	endfunction

endpackage

`default_nettype wire

FILE: design/brld_front.sv
`default_nettype none

module brld_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [brld_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic                          start_image,
	output logic                               item_valid,
	output brld_pkg::byte_item_t               item,
	input  wire logic                          item_pop
);

	brld_pkg::byte_item_t             queue_q [brld_pkg::QUEUE_DEPTH];
	logic [brld_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [brld_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [brld_pkg::QCNT_W-1:0]      count_q;
	logic                             push;
	logic                             pop;
	brld_pkg::byte_item_t             new_item;

	always_comb begin
		new_item.data  = data_byte;
		new_item.start = start_image;
		if (data_byte == '0) begin
			new_item.cls = brld_pkg::CLS_ZERO;
		end else if (data_byte == brld_pkg::TAG_LITERAL) begin
			new_item.cls = brld_pkg::CLS_LITERAL;
		end else if (data_byte == brld_pkg::BYTE_ONES) begin
			new_item.cls = brld_pkg::CLS_ONES;
		end else begin
			new_item.cls = brld_pkg::CLS_OTHER;
		end
	end

	assign in_stall   = (count_q == brld_pkg::QCNT_W'(brld_pkg::QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign item_valid = (count_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + brld_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + brld_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + brld_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - brld_pkg::QCNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= brld_pkg::QCNT_W'(brld_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + brld_pkg::QCNT_W'(1))
		else $error("queue count missed a push");

	assert property (@(posedge clk) disable iff (!arst_n)
		((wr_ptr_q - rd_ptr_q) == count_q[brld_pkg::QPTR_W-1:0]))
		else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: design/brld_back.sv
`default_nettype none

module brld_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire brld_pkg::cfg_wr_t    cfg_wr,
	input  wire logic                 item_valid,
	input  wire brld_pkg::byte_item_t item,
	output logic                      item_pop,
	output logic                      res_valid,
	output brld_pkg::result_t         res,
	input  wire logic                 res_stall
);

	logic [brld_pkg::PLEN_W-1:0]  pat_len_q;
	logic [brld_pkg::LINE_W-1:0]  line_bytes_q;

	brld_pkg::phase_t             phase_q;
	logic [brld_pkg::BYTE_W-1:0]  run_count_q;
	logic [brld_pkg::BYTE_W-1:0]  pattern_store_q [brld_pkg::MAX_PATTERN];
	logic [brld_pkg::IDX_W-1:0]   pattern_index_q;
	logic [brld_pkg::LINE_W-1:0]  line_left_q;
	logic                         at_line_start_q;
	logic [1:0]                   prefix_seen_q;

	logic                         out_valid_q;
	brld_pkg::result_t            out_q;

	// State as seen by this byte, after an optional image restart.
	brld_pkg::phase_t             cur_phase;
	logic [brld_pkg::BYTE_W-1:0]  cur_count;
	logic [brld_pkg::IDX_W-1:0]   cur_index;
	logic [brld_pkg::LINE_W-1:0]  cur_left;
	logic                         cur_start;
	logic [1:0]                   cur_prefix;

	brld_pkg::phase_t             phase_d;
	logic [brld_pkg::BYTE_W-1:0]  count_d;
	logic [brld_pkg::IDX_W-1:0]   index_d;
	logic [brld_pkg::LINE_W-1:0]  left_d;
	logic                         start_d;
	logic [1:0]                   prefix_d;
	logic                         store_we;
	logic                         emit;
	brld_pkg::result_t            res_d;

	logic [brld_pkg::PLEN_W-1:0]  plen;
	logic [brld_pkg::LINE_W-1:0]  reload;
	logic [brld_pkg::PROD_W-1:0]  pattern_bytes;
	logic [brld_pkg::LINE_W-1:0]  lit_left;
	logic [brld_pkg::BYTE_W-1:0]  tag_count;
	brld_pkg::line_upd_t          upd;
	logic                         take;

	assign take     = item_valid && (!out_valid_q || !res_stall);
	assign item_pop = take;

	assign plen          = brld_pkg::eff_pattern(pat_len_q);
	assign reload        = brld_pkg::eff_line(line_bytes_q);
	assign pattern_bytes = brld_pkg::PROD_W'(cur_count) * brld_pkg::PROD_W'(plen);
	assign tag_count     = item.data & brld_pkg::COUNT_MASK;

	always_comb begin
		if (item.start) begin
			cur_phase  = brld_pkg::PH_TAG;
			cur_count  = '0;
			cur_index  = '0;
			cur_left   = reload;
			cur_start  = 1'b1;
			cur_prefix = '0;
		end else begin
			cur_phase  = phase_q;
			cur_count  = run_count_q;
			cur_index  = pattern_index_q;
			cur_left   = line_left_q;
			cur_start  = at_line_start_q;
			cur_prefix = prefix_seen_q;
		end
	end

	always_comb begin
		phase_d  = cur_phase;
		count_d  = cur_count;
		index_d  = cur_index;
		left_d   = cur_left;
		start_d  = cur_start;
		prefix_d = cur_prefix;
		store_we = 1'b0;
		emit     = 1'b0;
		res_d    = '0;
		upd      = '0;
		lit_left = (cur_left != '0) ? cur_left - brld_pkg::LINE_W'(1) : '0;

		unique case (cur_phase)
			brld_pkg::PH_PAT_COUNT: begin
				prefix_d = (cur_prefix == 2'd1 && item.cls == brld_pkg::CLS_ZERO) ? 2'd2 : 2'd0;
				count_d  = item.data;
				index_d  = '0;
				phase_d  = brld_pkg::PH_PAT_BYTES;
			end
			brld_pkg::PH_PAT_BYTES: begin
				if (cur_prefix == 2'd2 && cur_index == '0 && item.cls == brld_pkg::CLS_ONES) begin
					prefix_d = 2'd3;
					phase_d  = brld_pkg::PH_REPEAT_N;
				end else begin
					prefix_d = '0;
					store_we = 1'b1;
					if ({1'b0, cur_index} + brld_pkg::PLEN_W'(1) >= plen) begin
						phase_d = brld_pkg::PH_TAG;
						index_d = '0;
						if (cur_count != '0) begin
							upd    = brld_pkg::line_consume(cur_left,
								brld_pkg::LINE_W'(pattern_bytes), reload);
							left_d = upd.left;
							if (upd.done) begin
								start_d = 1'b1;
							end
							emit = 1'b1;
							res_d.kind = brld_pkg::KIND_DATA;
							for (int k = 0; k < brld_pkg::MAX_PATTERN; k++) begin
								if (brld_pkg::PLEN_W'(k) < plen) begin
									res_d.run_data[8*k +: 8] =
										(brld_pkg::IDX_W'(k) == cur_index) ?
										item.data : pattern_store_q[k];
								end
							end
							res_d.byte_count  = plen;
							res_d.repeat_res  = cur_count;
							res_d.end_of_line = upd.done;
						end
					end else begin
						index_d = cur_index + brld_pkg::IDX_W'(1);
					end
				end
			end
			brld_pkg::PH_LIT_COUNT: begin
				count_d = item.data;
				phase_d = (item.cls == brld_pkg::CLS_ZERO) ? brld_pkg::PH_TAG :
					brld_pkg::PH_LIT_BYTES;
			end
			brld_pkg::PH_LIT_BYTES: begin
				count_d = cur_count - brld_pkg::BYTE_W'(1);
				left_d  = lit_left;
				if (count_d == '0) begin
					phase_d = brld_pkg::PH_TAG;
					upd     = brld_pkg::line_consume(lit_left, '0, reload);
					left_d  = upd.left;
					if (upd.done) begin
						start_d = 1'b1;
					end
				end
				emit = 1'b1;
				res_d.kind        = brld_pkg::KIND_DATA;
				res_d.run_data    = brld_pkg::DATA_W'(item.data);
				res_d.byte_count  = brld_pkg::PLEN_W'(1);
				res_d.repeat_res  = brld_pkg::BYTE_W'(1);
				res_d.end_of_line = upd.done;
			end
			brld_pkg::PH_REPEAT_N: begin
				prefix_d = '0;
				phase_d  = brld_pkg::PH_TAG;
				emit     = 1'b1;
				res_d.kind       = brld_pkg::KIND_REPEAT;
				res_d.repeat_res = (item.cls == brld_pkg::CLS_ZERO) ?
					brld_pkg::BYTE_W'(1) : item.data;
			end
			default: begin
				// Expecting a tag; stray phase codes land here as well.
				phase_d  = brld_pkg::PH_TAG;
				prefix_d = (cur_start && item.cls == brld_pkg::CLS_ZERO) ? 2'd1 : 2'd0;
				start_d  = 1'b0;
				unique case (item.cls)
					brld_pkg::CLS_ZERO: begin
						phase_d = brld_pkg::PH_PAT_COUNT;
					end
					brld_pkg::CLS_LITERAL: begin
						phase_d = brld_pkg::PH_LIT_COUNT;
					end
					default: begin
						upd    = brld_pkg::line_consume(cur_left,
							brld_pkg::LINE_W'(tag_count), reload);
						left_d = upd.left;
						if (upd.done) begin
							start_d = 1'b1;
						end
						emit = 1'b1;
						res_d.kind        = brld_pkg::KIND_DATA;
						res_d.run_data    = item.data[7] ?
							brld_pkg::DATA_W'(brld_pkg::BYTE_ONES) : '0;
						res_d.byte_count  = brld_pkg::PLEN_W'(1);
						res_d.repeat_res  = tag_count;
						res_d.end_of_line = upd.done;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= brld_pkg::PH_TAG;
		end else if (take) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q        <= brld_pkg::PAT_LEN_RESET;
			line_bytes_q     <= brld_pkg::LINE_BYTES_RESET;
			run_count_q      <= '0;
			pattern_index_q  <= '0;
			line_left_q      <= brld_pkg::LINE_BYTES_RESET;
			at_line_start_q  <= 1'b1;
			prefix_seen_q    <= '0;
		end else begin
			if (cfg_wr.valid && cfg_wr.index == brld_pkg::REG_PAT_LEN) begin
				pat_len_q <= cfg_wr.data[brld_pkg::PLEN_W-1:0];
			end
			if (cfg_wr.valid && cfg_wr.index == brld_pkg::REG_LINE_BYTES) begin
				line_bytes_q <= cfg_wr.data[brld_pkg::LINE_W-1:0];
			end
			if (take) begin
				run_count_q     <= count_d;
				pattern_index_q <= index_d;
				line_left_q     <= left_d;
				at_line_start_q <= start_d;
				prefix_seen_q   <= prefix_d;
			end else if (cfg_wr.valid && cfg_wr.index == brld_pkg::REG_LINE_BYTES &&
				at_line_start_q) begin
				// A new line length applies at once only between lines.
				line_left_q <= brld_pkg::eff_line(cfg_wr.data[brld_pkg::LINE_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && store_we) begin
			pattern_store_q[cur_index] <= item.data;
		end
		if (take && emit) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == brld_pkg::PH_REPEAT_N |-> prefix_seen_q == 2'd3)
		else $error("repeat count phase without a full line prefix");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != brld_pkg::PH_LIT_BYTES |-> line_left_q != '0)
		else $error("line left at zero outside a literal run");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != brld_pkg::PH_PAT_BYTES |-> pattern_index_q == '0)
		else $error("pattern index left set outside a pattern run");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == brld_pkg::PH_LIT_BYTES |-> run_count_q != '0)
		else $error("literal run phase with zero bytes left");

endmodule

`default_nettype wire

FILE: design/bitmap_rle_line_decoder_core.sv
// Run-length line decoder for compressed bitmap streams.
// Input channel: one compressed byte per transaction (data_byte), with
// start_image set on the first byte of an image to clear the parse state.
// A transaction completes on a rising edge with in_valid high and in_stall low.
// Output channel: one run descriptor or line-repeat marker per transaction,
// completed on a rising edge with out_valid high and out_stall low. Pattern
// and literal tags, counts and inner pattern bytes only advance the parser and give none.
// Configuration: cfg_ready is always high; write the pattern length (index 0)
// or line_bytes (index 1) only while no byte is in flight.
// Throughput is one byte per cycle, set by the parse step of the back end,
// while the output is not stalled. Accepted bytes go through a four-entry
// byte queue to the parser, which registers each result for output. in_stall
// rises only after the output has been stalled long enough to fill the queue;
// the result register holds steady while out_stall is high. Reset clears the
// queue and the output, sets the pattern length to 2 and line_bytes to 80,
// and starts at a line start.
`default_nettype none

module bitmap_rle_line_decoder_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [brld_pkg::BYTE_W-1:0]       data_byte,
	input  wire logic                              start_image,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   kind,
	output logic [brld_pkg::DATA_W-1:0]           run_data,
	output logic [brld_pkg::PLEN_W-1:0]           byte_count,
	output logic [brld_pkg::BYTE_W-1:0]           repeat_res,
	output logic                                   end_of_line,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [brld_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [brld_pkg::CFG_DATA_W-1:0]   cfg_data
);

	brld_pkg::byte_item_t  item;
	logic                  item_valid;
	logic                  item_pop;
	brld_pkg::cfg_wr_t     cfg_wr;
	brld_pkg::result_t     res;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid && cfg_ready;
	assign cfg_wr.index = brld_pkg::cfg_reg_t'(cfg_index);
	assign cfg_wr.data  = cfg_data;

	brld_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.start_image (start_image),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop)
	);

	brld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_valid  (out_valid),
		.res        (res),
		.res_stall  (out_stall)
	);

	assign kind        = res.kind;
	assign run_data    = res.run_data;
	assign byte_count  = res.byte_count;
	assign repeat_res  = res.repeat_res;
	assign end_of_line = res.end_of_line;

endmodule

`default_nettype wire
